@@ hw/rtl/mm_pkg.sv @@
// mm_pkg: shared constants, types and helpers of the matrix multiply block.
// No dependencies; used by mm_mac, mm_seq and matrix_multiply under hw/rtl.
`timescale 1ns / 1ps

package mm_pkg;

  localparam int MAX_DIM    = 8;
  localparam int ELEM_WIDTH = 16;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = 3;
  localparam int DIM_W  = 4;
  localparam int PROD_W = 2 * ELEM_WIDTH;
  localparam int ACC_W  = 35;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  typedef enum logic [1:0] {
    OP_WR_A    = 2'd0,
    OP_WR_B    = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_NOP     = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    REG_ROWS_A = 2'd0,
    REG_INNER  = 2'd1,
    REG_COLS_B = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_RUN,
    ST_DRAIN
  } seq_state_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

  typedef struct packed {
    logic             load;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } res_ctl_t;

  // Dimension register to 1..MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    begin
      if (d == '0) begin
        r = DIM_W'(1);
      end else if (d > DIM_W'(MAX_DIM)) begin
        r = DIM_W'(MAX_DIM);
      end else begin
        r = d;
      end
      return r;
    end
  endfunction

  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
    return ADDR_W'(int'(r) * MAX_DIM + int'(c));
  endfunction

endpackage

@@ hw/rtl/mm_ram.sv @@
// mm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/mm_mac.sv @@
// mm_mac: shared multiply-accumulate unit, product register then accumulator.
// Depends on mm_pkg.
`timescale 1ns / 1ps

module mm_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mm_pkg::mac_ctl_t                    ctl,
  input  logic signed [mm_pkg::ELEM_WIDTH-1:0] a_data,
  input  logic signed [mm_pkg::ELEM_WIDTH-1:0] b_data,
  output logic signed [mm_pkg::ACC_W-1:0]      acc,
  output logic                                done
);

  mm_pkg::mac_ctl_t                    c1_r, c2_r;
  logic signed [mm_pkg::PROD_W-1:0]    prod_r;
  logic signed [mm_pkg::ACC_W-1:0]     acc_r, acc_nxt;
  logic                                done_r;

  // c1 lines up with RAM read data, c2 with the product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r   <= '0;
      c2_r   <= '0;
      done_r <= 1'b0;
    end else begin
      c1_r   <= ctl;
      c2_r   <= c1_r;
      done_r <= c2_r.valid & c2_r.last;
    end
  end

  always_comb begin
    if (c2_r.first) begin
      acc_nxt = mm_pkg::ACC_W'(prod_r);
    end else begin
      acc_nxt = acc_r + mm_pkg::ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (c1_r.valid) begin
      prod_r <= a_data * b_data;
    end
    if (c2_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

@@ hw/rtl/mm_seq.sv @@
// mm_seq: sequencer stepping row, column and inner index of the product.
// Depends on mm_pkg.
`timescale 1ns / 1ps

module mm_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mm_pkg::DIM_W-1:0]    nr,
  input  logic [mm_pkg::DIM_W-1:0]    nk,
  input  logic [mm_pkg::DIM_W-1:0]    nc,
  input  logic                        out_free,
  input  logic                        mac_done,
  output logic                        idle,
  output logic [mm_pkg::ADDR_W-1:0]   rd_addr_a,
  output logic [mm_pkg::ADDR_W-1:0]   rd_addr_b,
  output mm_pkg::mac_ctl_t            mac_ctl,
  output mm_pkg::res_ctl_t            res
);

  mm_pkg::seq_state_t          state_r, state_nxt;
  logic [mm_pkg::IDX_W-1:0]    i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic                        k_last, j_last, i_last;

  assign k_last = ({1'b0, k_r} == (nk - mm_pkg::DIM_W'(1)));
  assign j_last = ({1'b0, j_r} == (nc - mm_pkg::DIM_W'(1)));
  assign i_last = ({1'b0, i_r} == (nr - mm_pkg::DIM_W'(1)));

  assign rd_addr_a = mm_pkg::elem_addr(i_r, k_r);
  assign rd_addr_b = mm_pkg::elem_addr(k_r, j_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mm_pkg::ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    idle          = 1'b0;
    mac_ctl       = '0;
    res           = '0;
    res.row       = i_r;
    res.col       = j_r;
    res.last      = i_last & j_last;
    case (state_r)
      mm_pkg::ST_IDLE: begin
        idle = 1'b1;
        if (start) begin
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          state_nxt = mm_pkg::ST_WAIT;
        end
      end
      mm_pkg::ST_WAIT: begin
        if (out_free) begin
          state_nxt = mm_pkg::ST_RUN;
        end
      end
      mm_pkg::ST_RUN: begin
        mac_ctl.valid = 1'b1;
        mac_ctl.first = (k_r == '0);
        mac_ctl.last  = k_last;
        if (k_last) begin
          k_nxt     = '0;
          state_nxt = mm_pkg::ST_DRAIN;
        end else begin
          k_nxt = k_r + mm_pkg::IDX_W'(1);
        end
      end
      mm_pkg::ST_DRAIN: begin
        if (mac_done) begin
          res.load = 1'b1;
          if (i_last && j_last) begin
            state_nxt = mm_pkg::ST_IDLE;
          end else begin
            state_nxt = mm_pkg::ST_WAIT;
            if (j_last) begin
              j_nxt = '0;
              i_nxt = i_r + mm_pkg::IDX_W'(1);
            end else begin
              j_nxt = j_r + mm_pkg::IDX_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = mm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/matrix_multiply.sv @@
// matrix_multiply: loads A and B element by element, then streams C = A * B.
// Element writes: one transfer per cycle while idle, no result.
// Compute: per result element a start step, inner MACs through one shared multiplier,
// then RAM read, product and accumulate stages; the start step waits while the
// output register is held; busy until the final element is loaded, no input transfer.
// Reset (rst_n, synchronous): dimensions to 1, sequencer idle, element stores kept.
`timescale 1ns / 1ps

module matrix_multiply (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            in_opcode,
  input  logic [mm_pkg::IDX_W-1:0]              in_row,
  input  logic [mm_pkg::IDX_W-1:0]              in_col,
  input  logic signed [mm_pkg::ELEM_WIDTH-1:0]  in_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [mm_pkg::IDX_W-1:0]              out_row,
  output logic [mm_pkg::IDX_W-1:0]              out_col,
  output logic signed [mm_pkg::ACC_W-1:0]       out_value,
  output logic                                  out_last,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [mm_pkg::CFG_AW-1:0]             paddr,
  input  logic [mm_pkg::CFG_DW-1:0]             pwdata,
  output logic [mm_pkg::CFG_DW-1:0]             prdata,
  output logic                                  pready
);

  logic [mm_pkg::DIM_W-1:0]       rows_a_r, inner_r, cols_b_r;
  logic [mm_pkg::DIM_W-1:0]       rd_val;
  logic                           cfg_wr;
  logic                           in_xfer, in_pos_ok, wr_a, wr_b, start;
  logic [mm_pkg::ADDR_W-1:0]      wr_addr, rd_addr_a, rd_addr_b;
  logic [mm_pkg::ELEM_WIDTH-1:0]  a_rdata, b_rdata;
  logic                           idle, out_free, mac_done;
  logic signed [mm_pkg::ACC_W-1:0] acc;
  mm_pkg::mac_ctl_t               mac_ctl;
  mm_pkg::res_ctl_t               res;

  logic                           out_valid_r, out_valid_nxt;
  logic [mm_pkg::IDX_W-1:0]       out_row_r, out_col_r;
  logic signed [mm_pkg::ACC_W-1:0] out_value_r;
  logic                           out_last_r;

  // Configuration
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= mm_pkg::DIM_W'(1);
      inner_r  <= mm_pkg::DIM_W'(1);
      cols_b_r <= mm_pkg::DIM_W'(1);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        mm_pkg::REG_ROWS_A: rows_a_r <= pwdata[mm_pkg::DIM_W-1:0];
        mm_pkg::REG_INNER:  inner_r  <= pwdata[mm_pkg::DIM_W-1:0];
        mm_pkg::REG_COLS_B: cols_b_r <= pwdata[mm_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      mm_pkg::REG_ROWS_A: rd_val = rows_a_r;
      mm_pkg::REG_INNER:  rd_val = inner_r;
      mm_pkg::REG_COLS_B: rd_val = cols_b_r;
      default:            rd_val = '0;
    endcase
  end

  assign prdata = mm_pkg::CFG_DW'(rd_val);

  // Input transfers
  assign in_ready  = idle;
  assign in_xfer   = in_valid & in_ready;
  assign in_pos_ok = (int'(in_row) < mm_pkg::MAX_DIM) && (int'(in_col) < mm_pkg::MAX_DIM);
  assign wr_a      = in_xfer && in_pos_ok && (in_opcode == mm_pkg::OP_WR_A);
  assign wr_b      = in_xfer && in_pos_ok && (in_opcode == mm_pkg::OP_WR_B);
  assign start     = in_xfer && (in_opcode == mm_pkg::OP_COMPUTE);
  assign wr_addr   = mm_pkg::elem_addr(in_row, in_col);

  mm_ram #(
    .WIDTH (mm_pkg::ELEM_WIDTH),
    .DEPTH (mm_pkg::DEPTH)
  ) u_store_a (
    .clk   (clk),
    .we    (wr_a),
    .waddr (wr_addr),
    .wdata (in_value),
    .raddr (rd_addr_a),
    .rdata (a_rdata)
  );

  mm_ram #(
    .WIDTH (mm_pkg::ELEM_WIDTH),
    .DEPTH (mm_pkg::DEPTH)
  ) u_store_b (
    .clk   (clk),
    .we    (wr_b),
    .waddr (wr_addr),
    .wdata (in_value),
    .raddr (rd_addr_b),
    .rdata (b_rdata)
  );

  mm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .nr        (mm_pkg::clamp_dim(rows_a_r)),
    .nk        (mm_pkg::clamp_dim(inner_r)),
    .nc        (mm_pkg::clamp_dim(cols_b_r)),
    .out_free  (out_free),
    .mac_done  (mac_done),
    .idle      (idle),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .mac_ctl   (mac_ctl),
    .res       (res)
  );

  mm_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .a_data ($signed(a_rdata)),
    .b_data ($signed(b_rdata)),
    .acc    (acc),
    .done   (mac_done)
  );

  // Output register
  assign out_free = ~out_valid_r | out_ready;

  always_comb begin
    if (res.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      out_row_r   <= res.row;
      out_col_r   <= res.col;
      out_value_r <= acc;
      out_last_r  <= res.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule
